// ===== design/prc_pkg.sv =====
// ----------------------------------------------------------------------------
// prc_pkg
// Widths, constants and register codes for the Lehmer rotation stream cipher.
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned SeedW  = 17;
  localparam int unsigned ProdW  = 24;   // 17-bit state times 75 stays below 2^24
  localparam int unsigned FoldW  = 16;
  localparam int unsigned OffW   = 7;    // offsets within the 96-value band
  localparam int unsigned CfgIdxW = 1;

  localparam logic [SeedW-1:0] LehmerMult = SeedW'(75);
  localparam logic [SeedW-1:0] LehmerMod  = SeedW'(65537);
  localparam logic [SeedW-1:0] SeedReset  = SeedW'(1);

  localparam logic [ByteW-1:0] BandLow  = ByteW'(32);
  localparam logic [ByteW-1:0] BandSize = ByteW'(128 - 32);

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [SeedW-1:0] seed_t;
  typedef logic [OffW-1:0]  off_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INITIAL_SEED = 1'b0,
    CFG_DECRYPT_MODE = 1'b1
  } cfg_idx_e;

endpackage

// ===== design/prc_if.sv =====
// ----------------------------------------------------------------------------
// prc_if
// Valid/ready stream channels for the cipher: input bytes and result bytes.
// ----------------------------------------------------------------------------
interface prc_in_if;
  logic               valid;
  logic               ready;
  prc_pkg::byte_t     data_byte;
  logic               start_of_message;

  modport source (output valid, output data_byte, output start_of_message, input ready);
  modport sink   (input valid, input data_byte, input start_of_message, output ready);
endinterface

interface prc_out_if;
  logic               valid;
  logic               ready;
  prc_pkg::byte_t     out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

// ===== design/prc_keystream.sv =====
// ----------------------------------------------------------------------------
// prc_keystream
// Lehmer generator mod 65537, multiplier 75, with reload from the seed.
// ----------------------------------------------------------------------------
module prc_keystream (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           reload_i,
  input  prc_pkg::seed_t seed_i,
  output prc_pkg::seed_t key_o
);
  import prc_pkg::*;

  seed_t              state_q;
  seed_t              base;
  logic [ProdW-1:0]   prod;
  logic [FoldW-1:0]   lo;
  logic [ProdW-FoldW-1:0] hi;
  seed_t              lo_x;
  seed_t              hi_x;

  // Fold: 2^16 == -1 mod 65537, so low half minus high half.
  always_comb begin
    base = reload_i ? seed_i : state_q;
    prod = ProdW'(base) * ProdW'(LehmerMult);
    lo   = prod[FoldW-1:0];
    hi   = prod[ProdW-1:FoldW];
    lo_x = SeedW'(lo);
    hi_x = SeedW'(hi);
    if (lo_x >= hi_x) begin
      key_o = lo_x - hi_x;
    end else begin
      key_o = lo_x + LehmerMod - hi_x;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SeedReset;
    end else if (adv_i) begin
      state_q <= key_o;
    end
  end

endmodule

// ===== design/prc_rotate.sv =====
// ----------------------------------------------------------------------------
// prc_rotate
// Rotate a printable byte within 32..127 by key mod 96; pass others through.
// ----------------------------------------------------------------------------
module prc_rotate (
  input  prc_pkg::byte_t data_i,
  input  prc_pkg::seed_t key_i,
  input  logic           decrypt_i,
  output prc_pkg::byte_t data_o
);
  import prc_pkg::*;

  localparam int unsigned HiW = SeedW - 5;

  logic [HiW-1:0]  key_hi;
  logic [HiW+12:0] quot_prod;
  logic [HiW-1:0]  quot;
  logic [HiW-1:0]  rem3_w;
  logic [1:0]      rem3;
  off_t            k96;
  off_t            off;
  logic [OffW:0]   sum;
  logic [OffW:0]   wrap;
  logic            printable;

  always_comb begin
    // key mod 96 = (key / 32 mod 3) * 32 + key mod 32
    key_hi    = key_i[SeedW-1:5];
    quot_prod = (HiW+13)'(key_hi) * (HiW+13)'(2731);   // /3 via reciprocal
    quot      = quot_prod[HiW+12:13];
    rem3_w    = key_hi - HiW'(quot * HiW'(3));
    rem3      = rem3_w[1:0];
    k96       = {rem3, key_i[4:0]};

    printable = (data_i >= BandLow) && !data_i[ByteW-1];
    off       = OffW'(data_i - BandLow);

    if (decrypt_i) begin
      sum  = {1'b0, off} - {1'b0, k96};
      wrap = sum + (OffW+1)'(BandSize);
      if (off < k96) begin
        sum = wrap;
      end
    end else begin
      sum  = {1'b0, off} + {1'b0, k96};
      wrap = sum - (OffW+1)'(BandSize);
      if (sum >= (OffW+1)'(BandSize)) begin
        sum = wrap;
      end
    end

    data_o = printable ? (ByteW'(sum) + BandLow) : data_i;
  end

endmodule

// ===== design/prng_rotation_stream_cipher.sv =====
// ----------------------------------------------------------------------------
// prng_rotation_stream_cipher
// Byte stream cipher: Lehmer keystream mod 65537 with printable-band rotation.
// ----------------------------------------------------------------------------
// One byte in, one byte out, in order. The block takes a byte in every cycle
// while the output accepts results, and returns each result through three
// registers: an input register, a key register that holds the freshly
// advanced generator value next to its byte, and the result register. The
// rate of one byte per cycle is set by the generator loop: the multiply by 75
// and the mod-65537 fold complete combinationally from the state register.
// Every byte advances the generator; a beat with start_of_message set first
// reloads the state from initial_seed. Bytes 32..127 are rotated by the key
// mod 96 within that band (up when encrypting, down when decrypting); every
// other byte passes unchanged. Write initial_seed and decrypt_mode only while
// no byte is in flight; a seed write takes effect at the next start of
// message. Backpressure on the output stalls the stages in turn, so up to
// three bytes are held before the input drops ready.
// ----------------------------------------------------------------------------
module prng_rotation_stream_cipher (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [prc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [prc_pkg::SeedW-1:0] cfg_wdata_i,
  prc_in_if.sink                    in_bus,
  prc_out_if.source                 out_bus
);
  import prc_pkg::*;

  // configuration
  seed_t  seed_q;
  logic   decrypt_q;

  // input stage
  logic   s1_vld_q;
  byte_t  s1_byte_q;
  logic   s1_sof_q;

  // key stage
  logic   s2_vld_q;
  byte_t  s2_byte_q;
  seed_t  s2_key_q;

  // result stage
  logic   out_vld_q;
  byte_t  out_byte_q;

  logic   out_free;
  logic   s2_free;
  logic   s1_free;
  logic   s1_move;
  logic   s2_move;
  logic   in_acc;
  seed_t  key_next;
  byte_t  rot_byte;

  // Configuration writes; an unknown index is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q    <= SeedReset;
      decrypt_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_INITIAL_SEED: seed_q    <= cfg_wdata_i;
        CFG_DECRYPT_MODE: decrypt_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Stage handshake: a stage takes a beat when it is empty or drains.
  assign out_free = !out_vld_q || out_bus.ready;
  assign s2_free  = !s2_vld_q || out_free;
  assign s1_free  = !s1_vld_q || s2_free;
  assign s2_move  = s2_vld_q && out_free;
  assign s1_move  = s1_vld_q && s2_free;
  assign in_acc   = in_bus.valid && s1_free;

  assign in_bus.ready = s1_free;

  // Advance the generator exactly when a byte leaves the input stage.
  prc_keystream u_keystream (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (s1_move),
    .reload_i (s1_sof_q),
    .seed_i   (seed_q),
    .key_o    (key_next)
  );

  prc_rotate u_rotate (
    .data_i    (s2_byte_q),
    .key_i     (s2_key_q),
    .decrypt_i (decrypt_q),
    .data_o    (rot_byte)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (s1_move) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_move) begin
        s2_vld_q <= 1'b1;
      end else if (s2_move) begin
        s2_vld_q <= 1'b0;
      end
      if (s2_move) begin
        out_vld_q <= 1'b1;
      end else if (out_bus.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers: load on a move, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= in_bus.data_byte;
      s1_sof_q  <= in_bus.start_of_message;
    end
    if (s1_move) begin
      s2_byte_q <= s1_byte_q;
      s2_key_q  <= key_next;
    end
    if (s2_move) begin
      out_byte_q <= rot_byte;
    end
  end

  assign out_bus.valid    = out_vld_q;
  assign out_bus.out_byte = out_byte_q;

endmodule
